@@ hdl/tbft_pkg.sv @@
// Package for the terrain block flatness triangulator: payload types and constants.
package tbft_pkg;

	localparam int HEIGHT_W   = 16;
	localparam int COORD_W    = 10;
	localparam int GRID_W     = 11;
	localparam int VERT_W     = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = COORD_W + GRID_W;

	localparam logic [GRID_W-1:0] MAX_GRID_SIDE = GRID_W'(1024);

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LIMIT = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0]  block_col;
		logic [COORD_W-1:0]  block_row;
		logic [HEIGHT_W-1:0] h_up_left;
		logic [HEIGHT_W-1:0] h_up_mid;
		logic [HEIGHT_W-1:0] h_up_right;
		logic [HEIGHT_W-1:0] h_mid_left;
		logic [HEIGHT_W-1:0] h_center;
		logic [HEIGHT_W-1:0] h_mid_right;
		logic [HEIGHT_W-1:0] h_low_left;
		logic [HEIGHT_W-1:0] h_low_mid;
		logic [HEIGHT_W-1:0] h_low_right;
	} block_t;

	typedef struct packed {
		logic [VERT_W-1:0] vert_a;
		logic [VERT_W-1:0] vert_b;
		logic [VERT_W-1:0] vert_c;
		logic              is_flat;
		logic              bad_block;
		logic              last_tri;
	} result_t;

endpackage

@@ hdl/terrain_block_flatness_triangulator_top.sv @@
// Top level of the terrain block flatness triangulator: test pipeline and triangle emitter.
//
//  Channel  Ports                          Transaction
//  -------  -----------------------------  -------------------------------------
//  block    start, busy, block_in          accepted when start is high, busy low
//  result   result_valid, result           one triangle per cycle, cannot stall
//  config   cfg_we, cfg_index, cfg_data    register write when cfg_we is high
//
// A block passes three pipeline stages (sums, test and multiply, indices) and is then
// handed to the emitter, which puts out one triangle per cycle: 1 for a bad block,
// 2 for a flat one, 8 otherwise. The emitter's triangle count sets the sustained rate.
// After stage three a block's triangles pass the emitter register and then the result register.
// Reset clears all valid bits and loads the register reset values.
// While the emitter works through a block the stages fill and hold; busy rises once
// stages one to three all hold a block and the emitter is not on its last triangle.
module terrain_block_flatness_triangulator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  tbft_pkg::block_t                     block_in,
	input  logic                                 cfg_we,
	input  logic [tbft_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tbft_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 result_valid,
	output tbft_pkg::result_t                    result
);

	// Configuration registers.
	logic [tbft_pkg::GRID_W-1:0]   grid_width_q;
	logic [tbft_pkg::GRID_W-1:0]   grid_height_q;
	logic [tbft_pkg::HEIGHT_W-1:0] slope_limit_q;

	// Stage 1: pair sums, limits, bounds check.
	logic                                 valid_s1;
	logic [tbft_pkg::COORD_W-1:0]         col_s1;
	logic [tbft_pkg::COORD_W-1:0]         row_s1;
	logic [tbft_pkg::GRID_W-1:0]          gw_s1;
	logic [tbft_pkg::HEIGHT_W:0]          sum_s1 [4];
	logic signed [tbft_pkg::HEIGHT_W+2:0] lo_s1;
	logic [tbft_pkg::HEIGHT_W+1:0]        hi_s1;
	logic                                 bad_s1;

	// Stage 2: flatness result and row product.
	logic                           valid_s2;
	logic [tbft_pkg::COORD_W-1:0]   col_s2;
	logic [tbft_pkg::GRID_W-1:0]    gw_s2;
	logic [tbft_pkg::PROD_W-1:0]    prod_s2;
	logic                           flat_s2;
	logic                           bad_s2;

	// Stage 3: row base indices.
	logic                         valid_s3;
	logic [tbft_pkg::VERT_W-1:0]  ul_s3;
	logic [tbft_pkg::VERT_W-1:0]  ml_s3;
	logic [tbft_pkg::VERT_W-1:0]  ll_s3;
	logic                         flat_s3;
	logic                         bad_s3;

	// Emitter.
	logic                         em_valid_q;
	logic [2:0]                   em_idx_q;
	logic                         em_flat_q;
	logic                         em_bad_q;
	logic [tbft_pkg::VERT_W-1:0]  em_ul_q;
	logic [tbft_pkg::VERT_W-1:0]  em_ml_q;
	logic [tbft_pkg::VERT_W-1:0]  em_ll_q;

	logic                         ready_s1;
	logic                         ready_s2;
	logic                         ready_s3;
	logic                         em_last;
	logic                         em_load;
	logic                         accept;

	logic [tbft_pkg::GRID_W-1:0]  gw_clamp;
	logic [tbft_pkg::GRID_W-1:0]  gh_clamp;
	logic [tbft_pkg::GRID_W:0]    col_ext;
	logic [tbft_pkg::GRID_W:0]    row_ext;
	logic [tbft_pkg::HEIGHT_W:0]  c2;
	logic [tbft_pkg::HEIGHT_W:0]  s2;
	logic [3:0]                   pass;
	logic [tbft_pkg::VERT_W-1:0]  ul_next;
	logic [tbft_pkg::VERT_W-1:0]  um;
	logic [tbft_pkg::VERT_W-1:0]  ur;
	logic [tbft_pkg::VERT_W-1:0]  mm;
	logic [tbft_pkg::VERT_W-1:0]  mr;
	logic [tbft_pkg::VERT_W-1:0]  lm;
	logic [tbft_pkg::VERT_W-1:0]  lr;
	tbft_pkg::result_t            tri_next;

	assign em_last  = em_bad_q || (em_flat_q ? (em_idx_q == 3'd1) : (em_idx_q == 3'd7));
	assign em_load  = !em_valid_q || em_last;
	assign ready_s3 = !valid_s3 || em_load;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign busy     = !ready_s1;
	assign accept   = start && ready_s1;

	// Stage 1 logic.
	always_comb begin
		gw_clamp = (grid_width_q > tbft_pkg::MAX_GRID_SIDE) ? tbft_pkg::MAX_GRID_SIDE
			: grid_width_q;
		gh_clamp = (grid_height_q > tbft_pkg::MAX_GRID_SIDE) ? tbft_pkg::MAX_GRID_SIDE
			: grid_height_q;
		col_ext = {2'b00, block_in.block_col} + (tbft_pkg::GRID_W+1)'(2);
		row_ext = {2'b00, block_in.block_row} + (tbft_pkg::GRID_W+1)'(2);
		c2 = {block_in.h_center, 1'b0};
		s2 = {slope_limit_q, 1'b0};
	end

	// Stage 2 logic: a pair passes when lo < a + b < hi.
	always_comb begin
		for (int p = 0; p < 4; p++) begin
			pass[p] = ($signed({2'b00, sum_s1[p]}) > lo_s1)
				&& ({1'b0, sum_s1[p]} < hi_s1);
		end
	end

	assign ul_next = tbft_pkg::VERT_W'(prod_s2 + tbft_pkg::PROD_W'(col_s2));

	// Emitter triangle selection.
	always_comb begin
		um = em_ul_q + tbft_pkg::VERT_W'(1);
		ur = em_ul_q + tbft_pkg::VERT_W'(2);
		mm = em_ml_q + tbft_pkg::VERT_W'(1);
		mr = em_ml_q + tbft_pkg::VERT_W'(2);
		lm = em_ll_q + tbft_pkg::VERT_W'(1);
		lr = em_ll_q + tbft_pkg::VERT_W'(2);
		tri_next = '0;
		tri_next.is_flat   = em_flat_q && !em_bad_q;
		tri_next.bad_block = em_bad_q;
		tri_next.last_tri  = em_last;
		if (em_bad_q) begin
			tri_next.is_flat = 1'b0;
		end else if (em_flat_q) begin
			if (em_idx_q[0]) begin
				tri_next.vert_a = lr;
				tri_next.vert_b = ur;
				tri_next.vert_c = em_ll_q;
			end else begin
				tri_next.vert_a = ur;
				tri_next.vert_b = em_ul_q;
				tri_next.vert_c = em_ll_q;
			end
		end else begin
			case (em_idx_q)
				3'd0: begin
					tri_next.vert_a = um; tri_next.vert_b = em_ul_q; tri_next.vert_c = em_ml_q;
				end
				3'd1: begin
					tri_next.vert_a = mm; tri_next.vert_b = um; tri_next.vert_c = em_ml_q;
				end
				3'd2: begin
					tri_next.vert_a = ur; tri_next.vert_b = um; tri_next.vert_c = mm;
				end
				3'd3: begin
					tri_next.vert_a = mr; tri_next.vert_b = ur; tri_next.vert_c = mm;
				end
				3'd4: begin
					tri_next.vert_a = mm; tri_next.vert_b = em_ml_q; tri_next.vert_c = em_ll_q;
				end
				3'd5: begin
					tri_next.vert_a = lm; tri_next.vert_b = mm; tri_next.vert_c = em_ll_q;
				end
				3'd6: begin
					tri_next.vert_a = mr; tri_next.vert_b = mm; tri_next.vert_c = lm;
				end
				default: begin
					tri_next.vert_a = lr; tri_next.vert_b = mr; tri_next.vert_c = lm;
				end
			endcase
		end
	end

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= tbft_pkg::GRID_W'(1024);
			grid_height_q <= tbft_pkg::GRID_W'(1024);
			slope_limit_q <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			em_valid_q    <= 1'b0;
			em_idx_q      <= '0;
			result_valid  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tbft_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data[tbft_pkg::GRID_W-1:0];
					tbft_pkg::REG_GRID_HEIGHT: grid_height_q <= cfg_data[tbft_pkg::GRID_W-1:0];
					tbft_pkg::REG_SLOPE_LIMIT: slope_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (ready_s1) valid_s1 <= start;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (em_load) begin
				em_valid_q <= valid_s3;
				em_idx_q   <= '0;
			end else begin
				em_idx_q <= em_idx_q + 3'd1;
			end
			result_valid <= em_valid_q;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= block_in.block_col;
			row_s1    <= block_in.block_row;
			gw_s1     <= gw_clamp;
			sum_s1[0] <= {1'b0, block_in.h_up_left}  + {1'b0, block_in.h_low_right};
			sum_s1[1] <= {1'b0, block_in.h_up_right} + {1'b0, block_in.h_low_left};
			sum_s1[2] <= {1'b0, block_in.h_mid_left} + {1'b0, block_in.h_mid_right};
			sum_s1[3] <= {1'b0, block_in.h_up_mid}   + {1'b0, block_in.h_low_mid};
			lo_s1     <= $signed({2'b00, c2}) - $signed({2'b00, s2});
			hi_s1     <= {1'b0, c2} + {1'b0, s2};
			bad_s1    <= (col_ext >= {1'b0, gw_clamp}) || (row_ext >= {1'b0, gh_clamp});
		end
		if (ready_s2 && valid_s1) begin
			col_s2  <= col_s1;
			gw_s2   <= gw_s1;
			prod_s2 <= tbft_pkg::PROD_W'(row_s1) * tbft_pkg::PROD_W'(gw_s1);
			flat_s2 <= &pass;
			bad_s2  <= bad_s1;
		end
		if (ready_s3 && valid_s2) begin
			ul_s3   <= ul_next;
			ml_s3   <= ul_next + tbft_pkg::VERT_W'(gw_s2);
			ll_s3   <= ul_next + tbft_pkg::VERT_W'({gw_s2, 1'b0});
			flat_s3 <= flat_s2;
			bad_s3  <= bad_s2;
		end
		if (em_load && valid_s3) begin
			em_ul_q   <= ul_s3;
			em_ml_q   <= ml_s3;
			em_ll_q   <= ll_s3;
			em_flat_q <= flat_s3;
			em_bad_q  <= bad_s3;
		end
		result <= tri_next;
	end

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the terrain block flatness triangulator top level.
`timescale 1ns / 100ps

module testbench;

	// Predicts the triangles of each accepted block and checks them in arrival order.
	class triangle_board;
		logic [tbft_pkg::GRID_W-1:0]   grid_w;
		logic [tbft_pkg::GRID_W-1:0]   grid_h;
		logic [tbft_pkg::HEIGHT_W-1:0] slope;
		tbft_pkg::result_t             expected_tris[$];
		int                            errors;
		int                            blocks;
		int                            flat_blocks;
		int                            bad_blocks;
		int                            tris_seen;
		int                            reg_writes;

		function new();
			grid_w = tbft_pkg::GRID_W'(1024);
			grid_h = tbft_pkg::GRID_W'(1024);
			slope  = '0;
		endfunction

		function void set_reg(logic [tbft_pkg::CFG_IDX_W-1:0] idx,
			logic [tbft_pkg::CFG_DATA_W-1:0] data);
			reg_writes++;
			case (idx)
				tbft_pkg::REG_GRID_WIDTH: begin
					grid_w = data[tbft_pkg::GRID_W-1:0];
				end
				tbft_pkg::REG_GRID_HEIGHT: begin
					grid_h = data[tbft_pkg::GRID_W-1:0];
				end
				tbft_pkg::REG_SLOPE_LIMIT: begin
					slope = data[tbft_pkg::HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// The pair midpoint must lie strictly inside the band around the centre height.
		function bit pair_ok(longint a, longint b, longint c, longint s);
			longint sum;
			sum = a + b;
			return (sum > 2 * c - 2 * s) && (sum < 2 * c + 2 * s);
		endfunction

		function void push_tri(longint a, longint b, longint c, bit flat, bit last);
			tbft_pkg::result_t r;
			r = '0;
			r.vert_a   = tbft_pkg::VERT_W'(a);
			r.vert_b   = tbft_pkg::VERT_W'(b);
			r.vert_c   = tbft_pkg::VERT_W'(c);
			r.is_flat  = flat;
			r.last_tri = last;
			expected_tris.push_back(r);
		endfunction

		function void note_block(tbft_pkg::block_t b);
			longint            gwe, ghe, col, row, ul, ml, ll, c, s;
			bit                flat;
			tbft_pkg::result_t r;
			blocks++;
			gwe = (grid_w > tbft_pkg::MAX_GRID_SIDE) ? longint'(tbft_pkg::MAX_GRID_SIDE)
				: longint'(grid_w);
			ghe = (grid_h > tbft_pkg::MAX_GRID_SIDE) ? longint'(tbft_pkg::MAX_GRID_SIDE)
				: longint'(grid_h);
			col = b.block_col;
			row = b.block_row;
			if (col + 2 >= gwe || row + 2 >= ghe) begin
				bad_blocks++;
				r = '0;
				r.bad_block = 1'b1;
				r.last_tri  = 1'b1;
				expected_tris.push_back(r);
				return;
			end
			ul = row * gwe + col;
			ml = ul + gwe;
			ll = ml + gwe;
			c  = b.h_center;
			s  = slope;
			flat = pair_ok(b.h_up_left, b.h_low_right, c, s) &&
			       pair_ok(b.h_up_right, b.h_low_left, c, s) &&
			       pair_ok(b.h_mid_left, b.h_mid_right, c, s) &&
			       pair_ok(b.h_up_mid, b.h_low_mid, c, s);
			if (flat) begin
				flat_blocks++;
				push_tri(ul + 2, ul, ll, 1'b1, 1'b0);
				push_tri(ll + 2, ul + 2, ll, 1'b1, 1'b1);
			end else begin
				push_tri(ul + 1, ul, ml, 1'b0, 1'b0);
				push_tri(ml + 1, ul + 1, ml, 1'b0, 1'b0);
				push_tri(ul + 2, ul + 1, ml + 1, 1'b0, 1'b0);
				push_tri(ml + 2, ul + 2, ml + 1, 1'b0, 1'b0);
				push_tri(ml + 1, ml, ll, 1'b0, 1'b0);
				push_tri(ll + 1, ml + 1, ll, 1'b0, 1'b0);
				push_tri(ml + 2, ml + 1, ll + 1, 1'b0, 1'b0);
				push_tri(ll + 2, ml + 2, ll + 1, 1'b0, 1'b1);
			end
		endfunction

		function void check_result(tbft_pkg::result_t r);
			tbft_pkg::result_t e;
			tris_seen++;
			if (expected_tris.size() == 0) begin
				errors++;
				$error("triangle result %h arrived with no block pending", r);
				return;
			end
			e = expected_tris.pop_front();
			if (r.vert_a !== e.vert_a) begin
				errors++;
				$error("vert_a: expected %0d, got %0d", e.vert_a, r.vert_a);
			end
			if (r.vert_b !== e.vert_b) begin
				errors++;
				$error("vert_b: expected %0d, got %0d", e.vert_b, r.vert_b);
			end
			if (r.vert_c !== e.vert_c) begin
				errors++;
				$error("vert_c: expected %0d, got %0d", e.vert_c, r.vert_c);
			end
			if (r.is_flat !== e.is_flat) begin
				errors++;
				$error("is_flat: expected %0b, got %0b", e.is_flat, r.is_flat);
			end
			if (r.bad_block !== e.bad_block) begin
				errors++;
				$error("bad_block: expected %0b, got %0b", e.bad_block, r.bad_block);
			end
			if (r.last_tri !== e.last_tri) begin
				errors++;
				$error("last_tri: expected %0b, got %0b", e.last_tri, r.last_tri);
			end
		endfunction

		function int pending();
			return expected_tris.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	tbft_pkg::block_t                block_in;
	logic                            cfg_we;
	logic [tbft_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tbft_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            result_valid;
	tbft_pkg::result_t               result;

	triangle_board tri_board;
	int            calm_left;

	terrain_block_flatness_triangulator_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.block_in     (block_in),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			tri_board.check_result(result);
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_block(tbft_pkg::block_t b);
		int gap;
		if (calm_left > 0) begin
			calm_left--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 24);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 3);
		end
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    = 1'b1;
		block_in = b;
		@(posedge clk);
		while (busy) @(posedge clk);
		tri_board.note_block(b);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [tbft_pkg::CFG_IDX_W-1:0] idx,
		logic [tbft_pkg::CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		tri_board.set_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Lets every pending triangle come out and the pipeline go quiet.
	task automatic settle();
		start = 1'b0;
		while (tri_board.pending() != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	function automatic tbft_pkg::block_t level_block(int col, int row,
		logic [tbft_pkg::HEIGHT_W-1:0] h);
		tbft_pkg::block_t b;
		b.block_col   = tbft_pkg::COORD_W'(col);
		b.block_row   = tbft_pkg::COORD_W'(row);
		b.h_up_left   = h;
		b.h_up_mid    = h;
		b.h_up_right  = h;
		b.h_mid_left  = h;
		b.h_center    = h;
		b.h_mid_right = h;
		b.h_low_left  = h;
		b.h_low_mid   = h;
		b.h_low_right = h;
		return b;
	endfunction

	function automatic logic [tbft_pkg::GRID_W-1:0] pick_side();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return tbft_pkg::GRID_W'($urandom_range(0, 2));
			1: return tbft_pkg::GRID_W'($urandom_range(1025, 2047));
			2: return tbft_pkg::GRID_W'(3);
			3: return tbft_pkg::GRID_W'(1024);
			default: return tbft_pkg::GRID_W'($urandom_range(3, 1024));
		endcase
	endfunction

	function automatic logic [tbft_pkg::HEIGHT_W-1:0] pick_slope();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return '1;
			2, 3, 4, 5: return tbft_pkg::HEIGHT_W'($urandom_range(0, 64));
			default: return tbft_pkg::HEIGHT_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Most blocks sit inside the grid with heights clustered around the
	// flatness band, so both the two- and eight-triangle paths are exercised.
	function automatic tbft_pkg::block_t random_block();
		int               gwe, ghe, sel, mode, c, s, t, d, a, k;
		int               hv[9];
		int               pa[4] = '{0, 2, 3, 1};
		int               pb[4] = '{8, 6, 5, 7};
		tbft_pkg::block_t b;
		gwe  = (tri_board.grid_w > 1024) ? 1024 : int'(tri_board.grid_w);
		ghe  = (tri_board.grid_h > 1024) ? 1024 : int'(tri_board.grid_h);
		sel  = $urandom_range(0, 99);
		if (sel < 10 || gwe < 3 || ghe < 3) begin
			b.block_col = tbft_pkg::COORD_W'($urandom);
			b.block_row = tbft_pkg::COORD_W'($urandom);
		end else if (sel < 22) begin
			b.block_col = tbft_pkg::COORD_W'(gwe - 3 + $urandom_range(0, 1));
			b.block_row = tbft_pkg::COORD_W'(ghe - 3 + $urandom_range(0, 1));
		end else begin
			b.block_col = tbft_pkg::COORD_W'($urandom_range(0, gwe - 3));
			b.block_row = tbft_pkg::COORD_W'($urandom_range(0, ghe - 3));
			if ($urandom_range(0, 3) != 0) begin
				b.block_col[0] = 1'b0;
				b.block_row[0] = 1'b0;
			end
		end
		mode = $urandom_range(0, 9);
		s    = int'(tri_board.slope);
		c    = $urandom_range(0, 65535);
		if (mode < 3) begin
			for (k = 0; k < 9; k++) hv[k] = $urandom_range(0, 65535);
		end else begin
			hv[4] = c;
			for (k = 0; k < 4; k++) begin
				if (mode == 9) begin
					case ($urandom_range(0, 3))
						0: d = -2 * s;
						1: d = 1 - 2 * s;
						2: d = 2 * s - 1;
						default: d = 2 * s;
					endcase
				end else begin
					d = int'($urandom_range(0, 4 * s + 4)) - (2 * s + 2);
				end
				t = 2 * c + d;
				if (t < 0) t = 0;
				if (t > 131070) t = 131070;
				a = $urandom_range((t > 65535) ? t - 65535 : 0, (t < 65535) ? t : 65535);
				hv[pa[k]] = a;
				hv[pb[k]] = t - a;
			end
		end
		b.h_up_left   = tbft_pkg::HEIGHT_W'(hv[0]);
		b.h_up_mid    = tbft_pkg::HEIGHT_W'(hv[1]);
		b.h_up_right  = tbft_pkg::HEIGHT_W'(hv[2]);
		b.h_mid_left  = tbft_pkg::HEIGHT_W'(hv[3]);
		b.h_center    = tbft_pkg::HEIGHT_W'(hv[4]);
		b.h_mid_right = tbft_pkg::HEIGHT_W'(hv[5]);
		b.h_low_left  = tbft_pkg::HEIGHT_W'(hv[6]);
		b.h_low_mid   = tbft_pkg::HEIGHT_W'(hv[7]);
		b.h_low_right = tbft_pkg::HEIGHT_W'(hv[8]);
		return b;
	endfunction

	initial begin
		#2_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		tbft_pkg::block_t blk;
		int               ph;
		arst_n    = 1'b0;
		start     = 1'b0;
		block_in  = '0;
		cfg_we    = 1'b0;
		cfg_index = tbft_pkg::REG_GRID_WIDTH;
		cfg_data  = '0;
		calm_left = 0;
		tri_board = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset values: full grid, zero slope, so nothing is flat.
		send_block(level_block(0, 0, 16'h0000));
		send_block(level_block(1021, 1021, 16'hFFFF));
		send_block(level_block(1022, 0, 16'h1234));
		send_block(level_block(0, 1022, 16'h1234));
		blk = '1;
		send_block(blk);
		blk = level_block(3, 5, 16'h0400);
		blk.h_low_mid = 16'h7FFF;
		send_block(blk);

		// A slope of one: sums exactly on the band edge fail, one inside passes.
		settle();
		write_reg(tbft_pkg::REG_SLOPE_LIMIT, 16'd1);
		blk = level_block(10, 20, 16'd500);
		send_block(blk);
		blk.h_up_left = 16'd502;
		send_block(blk);
		blk.h_up_left = 16'd501;
		send_block(blk);
		blk.h_up_mid = 16'd498;
		send_block(blk);
		blk.h_up_mid = 16'd500;
		blk.h_mid_left = 16'd499;
		send_block(blk);

		// Smallest grid with the widest slope.
		settle();
		write_reg(tbft_pkg::REG_SLOPE_LIMIT, 16'hFFFF);
		write_reg(tbft_pkg::REG_GRID_WIDTH, 16'd3);
		write_reg(tbft_pkg::REG_GRID_HEIGHT, 16'd3);
		send_block(level_block(0, 0, 16'hFFFF));
		blk = level_block(0, 0, 16'h0000);
		blk.h_center = 16'hFFFF;
		send_block(blk);
		blk = level_block(0, 0, 16'hFFFF);
		blk.h_center = 16'h0000;
		send_block(blk);
		send_block(level_block(1, 0, 16'h0001));
		send_block(level_block(0, 1, 16'h0001));

		// Oversized grid registers clamp; upper data bits are dropped.
		settle();
		write_reg(tbft_pkg::REG_GRID_WIDTH, 16'hF7FF);
		write_reg(tbft_pkg::REG_GRID_HEIGHT, 16'h0401);
		send_block(level_block(1021, 1021, 16'd7));
		send_block(level_block(1022, 4, 16'd7));

		// A grid too small to hold any block.
		settle();
		write_reg(tbft_pkg::REG_GRID_WIDTH, 16'd2);
		write_reg(tbft_pkg::REG_GRID_HEIGHT, 16'd1);
		send_block(level_block(0, 0, 16'h0100));

		for (ph = 0; ph < 9; ph++) begin
			settle();
			write_reg(tbft_pkg::REG_GRID_WIDTH, {5'($urandom), pick_side()});
			write_reg(tbft_pkg::REG_GRID_HEIGHT, {5'($urandom), pick_side()});
			write_reg(tbft_pkg::REG_SLOPE_LIMIT, pick_slope());
			repeat (30) send_block(random_block());
		end

		settle();
		$display("Sent %0d blocks: %0d flat, %0d outside the grid, %0d subdivided.",
			tri_board.blocks, tri_board.flat_blocks, tri_board.bad_blocks,
			tri_board.blocks - tri_board.flat_blocks - tri_board.bad_blocks);
		$display("Checked %0d triangles across %0d register writes.",
			tri_board.tris_seen, tri_board.reg_writes);
		if (tri_board.errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
